>>> rtl/assert_macros.svh
// Assertion macros for the sorted name table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define STN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define STN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define STN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/stn_pkg.sv
// Shared types and constants of the sorted name table.
// No dependencies; used by the interfaces, controller, datapath and top level.
package stn_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_IO_W  = 64;
  localparam int unsigned TAG_IO_W  = 16;
  localparam int unsigned POS_IO_W  = 7;
  localparam int unsigned STAT_W    = 2;

  // Cells reduced per scan step
  localparam int unsigned GRP_CELLS = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } stn_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } stn_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_APPLY
  } stn_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic compare;
    logic scan;
    logic apply;
  } stn_cmd_t;

endpackage

>>> rtl/stn_req_if.sv
// Request channel of the sorted name table: valid/ready plus one request beat.
// Depends on stn_pkg for field widths.
interface stn_req_if;
  logic                          valid;
  logic                          ready;
  logic [stn_pkg::OP_W-1:0]      operation;
  logic [stn_pkg::KEY_IO_W-1:0]  key;
  logic [stn_pkg::TAG_IO_W-1:0]  new_tag;
  logic [stn_pkg::TAG_IO_W-1:0]  body_size;

  modport source (output valid, operation, key, new_tag, body_size, input ready);
  modport sink   (input valid, operation, key, new_tag, body_size, output ready);
endinterface

>>> rtl/stn_rsp_if.sv
// Response channel of the sorted name table: valid/ready plus one result beat.
// Depends on stn_pkg for field widths.
interface stn_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stn_pkg::TAG_IO_W-1:0]  tag;
  logic [stn_pkg::POS_IO_W-1:0]  position;
  logic [stn_pkg::STAT_W-1:0]    status;
  logic [stn_pkg::POS_IO_W-1:0]  entries_used;

  modport source (output valid, found, tag, position, status, entries_used, input ready);
  modport sink   (input valid, found, tag, position, status, entries_used, output ready);
endinterface

>>> rtl/sorted_name_table.sv
// Sorted name table top level: joins the controller and the cell datapath.
// Depends on stn_pkg, stn_req_if, stn_rsp_if, stn_ctrl, stn_datapath and
// assert_macros.svh.
//
//  channel  dir  beat contents
//  req_i    in   operation, key, new_tag, body_size
//  rsp_o    out  found, tag, position, status, entries_used
//
// An accepted request passes through one capture, one parallel compare of all
// cells, one scan step per group of eight cells to sum the insertion point and
// pick the matched tag, and one apply.
// The result register lets the next request be taken while a result waits;
// apply holds until that register is free. Reset clears the entry count only,
// so the table is usable right after reset with no clearing pass.
`include "assert_macros.svh"

module sorted_name_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned NAME_CHARS  = 8,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  stn_req_if.sink        req_i,
  stn_rsp_if.source      rsp_o
);

  localparam int unsigned NGRP =
    (TABLE_DEPTH + stn_pkg::GRP_CELLS - 1) / stn_pkg::GRP_CELLS;
  localparam int unsigned POS_IO_W = stn_pkg::POS_IO_W;

  stn_pkg::stn_cmd_t cmd;

  stn_ctrl #(
    .SCAN_STEPS (NGRP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  stn_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_CHARS  (NAME_CHARS),
    .TAG_BITS    (TAG_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (req_i.operation),
    .key_i          (req_i.key),
    .new_tag_i      (req_i.new_tag),
    .body_size_i    (req_i.body_size),
    .found_o        (rsp_o.found),
    .tag_o          (rsp_o.tag),
    .position_o     (rsp_o.position),
    .status_o       (rsp_o.status),
    .entries_used_o (rsp_o.entries_used)
  );

  // One request in flight: no second beat right after an accepted one
  `STN_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request accepted back to back")
  // A commit always presents a result beat next cycle
  `STN_ASSERT_NEXT(a_apply_shows, clk_i, rst_ni, cmd.apply, rsp_o.valid, "commit without result beat")
  // Duplicate insert reports the existing entry
  `STN_ASSERT_IMPLY(a_dup_found, clk_i, rst_ni, rsp_o.valid && (rsp_o.status == stn_pkg::ST_DUP), rsp_o.found, "duplicate without match")
  // Full status only at capacity
  `STN_ASSERT_IMPLY(a_full_cap, clk_i, rst_ni, rsp_o.valid && (rsp_o.status == stn_pkg::ST_FULL), rsp_o.entries_used == POS_IO_W'(TABLE_DEPTH), "full below capacity")

endmodule

>>> rtl/stn_ctrl.sv
// Controller of the sorted name table: sequences capture, compare, scan, apply.
// Depends on stn_pkg for the state enum and command struct.
module stn_ctrl #(
  parameter int unsigned SCAN_STEPS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stn_pkg::stn_cmd_t cmd_o
);

  localparam int unsigned SCNT_W = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

  stn_pkg::stn_state_e state_q, state_d;
  logic [SCNT_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic                out_valid_q, out_valid_d;

  // State and handshake registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stn_pkg::S_IDLE;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    cmd_o      = '0;
    unique case (state_q)
      stn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stn_pkg::S_CMP;
        end
      end
      stn_pkg::S_CMP: begin
        cmd_o.compare = 1'b1;
        scan_cnt_d    = '0;
        state_d       = stn_pkg::S_SCAN;
      end
      stn_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (scan_cnt_q == SCNT_W'(SCAN_STEPS - 1)) begin
          state_d = stn_pkg::S_APPLY;
        end else begin
          scan_cnt_d = scan_cnt_q + SCNT_W'(1);
        end
      end
      stn_pkg::S_APPLY: begin
        // commit only once the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.apply = 1'b1;
          state_d     = stn_pkg::S_IDLE;
        end
      end
      default: state_d = stn_pkg::S_IDLE;
    endcase
  end

  // Result register occupancy
  always_comb begin
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == stn_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/stn_datapath.sv
// Datapath of the sorted name table: a row of key/tag cells with per-cell
// comparators, a group reducer scanned over cycles, and the result register.
// Depends on stn_pkg for widths, opcodes, status codes and the command struct.
module stn_datapath #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned NAME_CHARS  = 8,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stn_pkg::stn_cmd_t             cmd_i,
  input  logic [stn_pkg::OP_W-1:0]      operation_i,
  input  logic [stn_pkg::KEY_IO_W-1:0]  key_i,
  input  logic [stn_pkg::TAG_IO_W-1:0]  new_tag_i,
  input  logic [stn_pkg::TAG_IO_W-1:0]  body_size_i,
  output logic                          found_o,
  output logic [stn_pkg::TAG_IO_W-1:0]  tag_o,
  output logic [stn_pkg::POS_IO_W-1:0]  position_o,
  output logic [stn_pkg::STAT_W-1:0]    status_o,
  output logic [stn_pkg::POS_IO_W-1:0]  entries_used_o
);

  localparam int unsigned KEY_W    = 8 * NAME_CHARS;
  localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned GRP      = stn_pkg::GRP_CELLS;
  localparam int unsigned NGRP     = (TABLE_DEPTH + GRP - 1) / GRP;
  localparam int unsigned PAD_W    = NGRP * GRP;
  localparam int unsigned GCW      = $clog2(GRP + 1);
  localparam int unsigned TAG_IO_W = stn_pkg::TAG_IO_W;
  localparam int unsigned POS_IO_W = stn_pkg::POS_IO_W;

  // Cell storage
  logic [KEY_W-1:0]    cell_key_q [TABLE_DEPTH];
  logic [KEY_W-1:0]    cell_key_d [TABLE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag_q [TABLE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag_d [TABLE_DEPTH];
  logic [CNT_W-1:0]    count_q, count_d;

  // Captured request
  logic [stn_pkg::OP_W-1:0] op_q;
  logic [KEY_W-1:0]         probe_q;
  logic [TAG_BITS-1:0]      ntag_q;
  logic [TAG_BITS-1:0]      bsize_q;

  // Compare results
  logic [PAD_W-1:0]    lt_pad;
  logic [PAD_W-1:0]    eq_pad;
  logic [TAG_BITS-1:0] cell_ht [PAD_W];
  logic [TABLE_DEPTH-1:0] lt_q;

  // Group reduction and scan
  logic [GCW-1:0]      grp_cnt_d [NGRP];
  logic [GCW-1:0]      grp_cnt_q [NGRP];
  logic [NGRP-1:0]     grp_hit_d, grp_hit_q;
  logic [TAG_BITS-1:0] grp_tag_d [NGRP];
  logic [TAG_BITS-1:0] grp_tag_q [NGRP];
  logic [CNT_W-1:0]    pos_q;
  logic                hit_q;
  logic [TAG_BITS-1:0] hit_tag_q;

  // Apply control
  logic full;
  logic do_ins;
  logic do_rem;

  // Result register
  logic                  found_q;
  logic [TAG_IO_W-1:0]   tag_q;
  logic [POS_IO_W-1:0]   position_q;
  stn_pkg::stn_status_e  status_q, status_d;
  logic [POS_IO_W-1:0]   used_q;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      probe_q <= key_i[KEY_W-1:0];
      ntag_q  <= TAG_BITS'(new_tag_i);
      bsize_q <= TAG_BITS'(body_size_i);
    end
  end

  // Per-cell comparators, padded to whole groups
  for (genvar i = 0; i < PAD_W; i++) begin : g_cmp
    if (i < TABLE_DEPTH) begin : g_live
      logic live;
      assign live       = CNT_W'(i) < count_q;
      assign lt_pad[i]  = live && (cell_key_q[i] < probe_q);
      assign eq_pad[i]  = live && (cell_key_q[i] == probe_q);
      assign cell_ht[i] = eq_pad[i] ? cell_tag_q[i] : '0;
    end else begin : g_pad
      assign lt_pad[i]  = 1'b0;
      assign eq_pad[i]  = 1'b0;
      assign cell_ht[i] = '0;
    end
  end

  // Per-group count of smaller keys, hit flag and matched tag
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_cnt_d[g] = '0;
      grp_hit_d[g] = 1'b0;
      grp_tag_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_cnt_d[g] = grp_cnt_d[g] + GCW'(lt_pad[g*GRP + k]);
        grp_hit_d[g] = grp_hit_d[g] | eq_pad[g*GRP + k];
        grp_tag_d[g] = grp_tag_d[g] | cell_ht[g*GRP + k];
      end
    end
  end

  // Compare capture, then one group per scan step shifted toward slot 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      lt_q      <= lt_pad[TABLE_DEPTH-1:0];
      grp_hit_q <= grp_hit_d;
      for (int g = 0; g < NGRP; g++) begin
        grp_cnt_q[g] <= grp_cnt_d[g];
        grp_tag_q[g] <= grp_tag_d[g];
      end
      pos_q     <= '0;
      hit_q     <= 1'b0;
      hit_tag_q <= '0;
    end else if (cmd_i.scan) begin
      pos_q     <= pos_q + CNT_W'(grp_cnt_q[0]);
      hit_q     <= hit_q | grp_hit_q[0];
      hit_tag_q <= hit_tag_q | grp_tag_q[0];
      grp_hit_q <= grp_hit_q >> 1;
      for (int g = 0; g < NGRP - 1; g++) begin
        grp_cnt_q[g] <= grp_cnt_q[g+1];
        grp_tag_q[g] <= grp_tag_q[g+1];
      end
      grp_cnt_q[NGRP-1] <= '0;
      grp_tag_q[NGRP-1] <= '0;
    end
  end

  assign full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign do_ins = cmd_i.apply && (op_q == stn_pkg::OP_INSERT) && !hit_q && !full;
  assign do_rem = cmd_i.apply && (op_q == stn_pkg::OP_REMOVE) && hit_q;

  // Cell update: open a slot on insert, close it on remove, rebase larger tags
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                prev_lt;
    logic [KEY_W-1:0]    prev_key;
    logic [TAG_BITS-1:0] prev_tag;
    logic [KEY_W-1:0]    next_key;
    logic [TAG_BITS-1:0] next_tag;
    logic [TAG_BITS-1:0] tag_sel;

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b1;
      assign prev_key = probe_q;
      assign prev_tag = ntag_q;
    end else begin : g_body
      assign prev_lt  = lt_q[i-1];
      assign prev_key = cell_key_q[i-1];
      assign prev_tag = cell_tag_q[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_key = cell_key_q[i];
      assign next_tag = cell_tag_q[i];
    end else begin : g_inner
      assign next_key = cell_key_q[i+1];
      assign next_tag = cell_tag_q[i+1];
    end

    always_comb begin
      cell_key_d[i] = cell_key_q[i];
      tag_sel       = cell_tag_q[i];
      if (do_ins && !lt_q[i]) begin
        if (prev_lt) begin
          cell_key_d[i] = probe_q;
          tag_sel       = ntag_q;
        end else begin
          cell_key_d[i] = prev_key;
          tag_sel       = prev_tag;
        end
      end else if (do_rem && !lt_q[i]) begin
        cell_key_d[i] = next_key;
        tag_sel       = next_tag;
      end
      // tags above the removed one drop by the body size, wrapping
      if (do_rem && (tag_sel > hit_tag_q)) begin
        cell_tag_d[i] = tag_sel - bsize_q;
      end else begin
        cell_tag_d[i] = tag_sel;
      end
    end

    always_ff @(posedge clk_i) begin
      cell_key_q[i] <= cell_key_d[i];
      cell_tag_q[i] <= cell_tag_d[i];
    end
  end

  // Entry count
  always_comb begin
    priority if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Status code
  always_comb begin
    priority if (op_q == stn_pkg::OP_INSERT) begin
      if (hit_q) begin
        status_d = stn_pkg::ST_DUP;
      end else if (full) begin
        status_d = stn_pkg::ST_FULL;
      end else begin
        status_d = stn_pkg::ST_OK;
      end
    end else begin
      status_d = hit_q ? stn_pkg::ST_OK : stn_pkg::ST_NOT_FOUND;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      found_q    <= hit_q;
      tag_q      <= hit_q ? TAG_IO_W'(hit_tag_q) : '0;
      position_q <= POS_IO_W'(pos_q);
      status_q   <= status_d;
      used_q     <= POS_IO_W'(count_d);
    end
  end

  assign found_o        = found_q;
  assign tag_o          = tag_q;
  assign position_o     = position_q;
  assign status_o       = status_q;
  assign entries_used_o = used_q;

endmodule

>>> test/sorted_name_table_checker.sv
// Scoreboard for the sorted name table: watches both channels, predicts each result.
// Depends on stn_pkg, stn_req_if and stn_rsp_if.
module sorted_name_table_checker
  import stn_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned NAME_CHARS  = 8,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stn_req_if          req_i,
  stn_rsp_if          rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_due_o
);

  localparam logic [KEY_IO_W-1:0] KEY_MASK =
      (NAME_CHARS >= 8) ? '1 : ((64'd1 << (8 * NAME_CHARS)) - 64'd1);
  localparam logic [31:0] TAG_MASK =
      (TAG_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TAG_BITS) - 32'd1);

  typedef struct packed {
    logic                found;
    logic [TAG_IO_W-1:0] tag;
    logic [POS_IO_W-1:0] position;
    stn_status_e         status;
    logic [POS_IO_W-1:0] entries_used;
  } name_result_t;

  // Shadow copy of the sorted table
  logic [KEY_IO_W-1:0] table_keys [TABLE_DEPTH];
  logic [31:0]         table_tags [TABLE_DEPTH];
  int unsigned         table_count = 0;

  name_result_t pending_results [$];

  // Applies one request to the shadow table and returns the result it yields.
  function automatic name_result_t resolve_request(
    input logic [OP_W-1:0]     op,
    input logic [KEY_IO_W-1:0] key_raw,
    input logic [TAG_IO_W-1:0] tag_raw,
    input logic [TAG_IO_W-1:0] shrink
  );
    logic [KEY_IO_W-1:0] key;
    logic [31:0]         fresh_tag;
    logic [31:0]         hit_tag;
    logic                hit;
    int unsigned         n;
    int unsigned         pos;
    int unsigned         i;
    name_result_t        res;
    key       = key_raw & KEY_MASK;
    fresh_tag = {16'd0, tag_raw} & TAG_MASK;
    n         = table_count;
    pos       = 0;
    hit       = 1'b0;
    hit_tag   = '0;
    // insertion point = number of smaller keys
    while (pos < n && table_keys[pos] < key) pos++;
    if (pos < n && table_keys[pos] == key) begin
      hit     = 1'b1;
      hit_tag = table_tags[pos];
    end
    res.status = hit ? ST_OK : ST_NOT_FOUND;
    if (op == OP_INSERT) begin
      // duplicate wins over full
      if (hit) begin
        res.status = ST_DUP;
      end else if (n >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (i = n; i > pos; i--) begin
          table_keys[i] = table_keys[i-1];
          table_tags[i] = table_tags[i-1];
        end
        table_keys[pos] = key;
        table_tags[pos] = fresh_tag;
        n++;
        res.status = ST_OK;
      end
    end else if (op == OP_REMOVE) begin
      if (hit) begin
        for (i = pos; i + 1 < n; i++) begin
          table_keys[i] = table_keys[i+1];
          table_tags[i] = table_tags[i+1];
        end
        n--;
        // close the gap left by the removed body; wraps on underflow
        for (i = 0; i < n; i++) begin
          if (table_tags[i] > hit_tag)
            table_tags[i] = (table_tags[i] - {16'd0, shrink}) & TAG_MASK;
        end
      end
    end
    // any other code behaves as a lookup
    table_count      = n;
    res.found        = hit;
    res.tag          = hit ? hit_tag[TAG_IO_W-1:0] : '0;
    res.position     = pos[POS_IO_W-1:0];
    res.entries_used = n[POS_IO_W-1:0];
    return res;
  endfunction

  // Compare result beats first, then queue the prediction for a new request beat
  always @(posedge clk_i) begin : watch
    name_result_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("[%0t] result beat with nothing pending: found=%0b tag=%h pos=%0d",
                     $realtime, rsp_i.found, rsp_i.tag, rsp_i.position);
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.found !== want.found || rsp_i.tag !== want.tag ||
              rsp_i.position !== want.position || rsp_i.status !== want.status ||
              rsp_i.entries_used !== want.entries_used) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("[%0t] mismatch: got found=%0b tag=%h pos=%0d st=%0d used=%0d",
                       $realtime, rsp_i.found, rsp_i.tag, rsp_i.position, rsp_i.status,
                       rsp_i.entries_used);
              $display("[%0t]     want found=%0b tag=%h pos=%0d st=%0d used=%0d",
                       $realtime, want.found, want.tag, want.position, want.status,
                       want.entries_used);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready)
        pending_results.push_back(resolve_request(req_i.operation, req_i.key,
                                                  req_i.new_tag, req_i.body_size));
      results_due_o = pending_results.size();
    end
  end

endmodule

>>> test/sorted_name_table_tb.sv
// Top of the sorted name table testbench: clock, reset, request and response drivers.
// Depends on stn_pkg, stn_req_if, stn_rsp_if, sorted_name_table and the checker.
module sorted_name_table_tb;
  import stn_pkg::*;

  // Code 3 is not an operation; the table treats it as a lookup
  localparam logic [OP_W-1:0] OP_LOOKUP_ALIAS = 2'd3;
  localparam int unsigned     KEY_POOL_SIZE   = 96;
  localparam int unsigned     LONG_HOLD       = 150;
  localparam int unsigned     TAIL_CYCLES     = 40;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned results_due;

  stn_req_if req_if ();
  stn_rsp_if rsp_if ();

  logic [KEY_IO_W-1:0] key_pool [KEY_POOL_SIZE];
  int unsigned         beats_left_in_burst = 0;
  bit                  long_hold_req  = 1'b0;
  bit                  long_hold_done = 1'b0;

  sorted_name_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sorted_name_table_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // Response side: stall modes picked at random, plus one long hold-off on request
  initial begin : rsp_drain
    int unsigned cyc;
    int unsigned hold_left;
    int unsigned stall_mode;
    rsp_if.ready = 1'b0;
    cyc        = 0;
    hold_left  = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (cyc % 200 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_if.ready <= ((cyc % 9) >= 5);
          default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Drives one request beat from a falling edge and returns at a falling edge
  task automatic offer_request(input logic [OP_W-1:0] op, input logic [KEY_IO_W-1:0] key,
                               input logic [TAG_IO_W-1:0] tag,
                               input logic [TAG_IO_W-1:0] shrink);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key       <= key;
    req_if.new_tag   <= tag;
    req_if.body_size <= shrink;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
    if (beats_left_in_burst != 0) begin
      beats_left_in_burst--;
    end else begin
      beats_left_in_burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Holds the request side idle until every pending result has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    wait (results_due == 0);
    @(negedge clk_i);
  endtask

  function automatic logic [TAG_IO_W-1:0] pick_body_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return TAG_IO_W'($urandom_range(1, 64));
      2: return TAG_IO_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic logic [KEY_IO_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  // One random request; weights in percent, the remainder goes to the alias code
  task automatic random_request(input int unsigned look_w, input int unsigned ins_w,
                                input int unsigned rem_w);
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    roll = $urandom_range(0, 99);
    if (roll < look_w)                      op = OP_LOOKUP;
    else if (roll < look_w + ins_w)         op = OP_INSERT;
    else if (roll < look_w + ins_w + rem_w) op = OP_REMOVE;
    else                                    op = OP_LOOKUP_ALIAS;
    offer_request(op, pick_key(), TAG_IO_W'($urandom), pick_body_size());
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned len;
    int unsigned c;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_LOOKUP;
    req_if.key       = '0;
    req_if.new_tag   = '0;
    req_if.body_size = '0;

    // Key pool: extremes, name-like strings, shared prefixes, raw values
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) begin
      case (i % 4)
        0: key_pool[i] = {$urandom, $urandom};
        1: begin
          key_pool[i] = '0;
          len = $urandom_range(1, 8);
          for (c = 0; c < len; c++)
            key_pool[i][63 - 8*c -: 8] = 8'($urandom_range(65, 90));
        end
        2: key_pool[i] = {48'h5445_5354_4142, 16'($urandom)};
        default: key_pool[i] = {32'd0, $urandom};
      endcase
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, extremes, duplicate, alias code, wrapping remove
    offer_request(OP_LOOKUP, '0, '0, '0);
    offer_request(OP_REMOVE, '1, '0, '1);
    offer_request(OP_INSERT, '1, '1, '0);
    offer_request(OP_INSERT, '0, '0, '1);
    offer_request(OP_INSERT, 64'h4142_4344_0000_0000, 16'h8000, '0);
    offer_request(OP_INSERT, 64'h4142_4300_0000_0000, 16'h0001, '0);
    offer_request(OP_INSERT, 64'h4142_4345_0000_0000, 16'h7FFF, '0);
    offer_request(OP_INSERT, '0, 16'h1234, '0);
    offer_request(OP_LOOKUP, '1, '0, '0);
    offer_request(OP_LOOKUP_ALIAS, 64'h4142_4300_0000_0000, '0, '0);
    offer_request(OP_LOOKUP_ALIAS, 64'h4142_4343_0000_0000, '0, '0);
    offer_request(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
    offer_request(OP_INSERT, 64'h5555_5555_5555_5555, 16'hAAAA, '0);
    offer_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, '1);
    offer_request(OP_REMOVE, 64'h4142_4344_0000_0000, '1, 16'h0100);
    offer_request(OP_REMOVE, '0, '0, '1);
    offer_request(OP_REMOVE, 64'h4142_4344_0000_0000, '0, '0);
    offer_request(OP_LOOKUP, 64'h5555_5555_5555_5555, '0, '0);
    offer_request(OP_REMOVE, '1, '0, '0);
    offer_request(OP_INSERT, '0, '0, '0);
    drain_results();

    // Mixed traffic
    repeat (100) random_request(30, 40, 25);
    drain_results();

    // Fill past capacity while the response side holds off
    long_hold_req = 1'b1;
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      if ($urandom_range(0, 99) < 85)
        offer_request(OP_INSERT, key_pool[i], TAG_IO_W'($urandom), pick_body_size());
      else
        random_request(40, 20, 35);
    end
    repeat (30) random_request(10, 80, 5);
    drain_results();

    // Drain the table
    repeat (130) random_request(20, 20, 58);
    drain_results();

    // Mixed traffic again
    repeat (130) random_request(25, 45, 25);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sorted_name_table.f
+incdir+rtl
rtl/stn_pkg.sv
rtl/stn_req_if.sv
rtl/stn_rsp_if.sv
rtl/stn_ctrl.sv
rtl/stn_datapath.sv
rtl/sorted_name_table.sv
test/sorted_name_table_checker.sv
test/sorted_name_table_tb.sv
